// File: rtl/lagr_pkg.sv
// Shared types and codes for the Lagrange interpolation evaluator.
package lagr_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_EVAL   = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_DUP   = 3'd2,
    ST_FULL  = 3'd3,
    ST_OVF   = 3'd4
  } status_t;

  localparam int unsigned WORD_W = 32;

endpackage

// File: rtl/lagr_if.sv
// Valid/ready channel interfaces for requests and results of the evaluator.
interface lagr_req_if;
  logic                    valid;
  logic                    ready;
  lagr_pkg::action_t       action;
  logic signed [31:0]      point_x;
  logic signed [31:0]      point_y;
  logic signed [31:0]      query_x;
  modport source (output valid, action, point_x, point_y, query_x, input ready);
  modport sink (input valid, action, point_x, point_y, query_x, output ready);
endinterface

interface lagr_rsp_if;
  logic                    valid;
  logic                    ready;
  logic signed [31:0]      value;
  lagr_pkg::status_t       status;
  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

// File: rtl/lagrange_interpolation_eval_core.sv
// Lagrange interpolation evaluator: point table in memory with a shared serial divider.
// One request is handled at a time; a new request is taken while the previous result
// still waits in the output register. Clear and ignored actions go straight to the result,
// an append makes one memory read per duplicate compare against each of the n stored
// points, and an evaluate forms n*(n-1) ratios with the restoring divider, which retires
// one quotient bit per cycle.
module lagrange_interpolation_eval_core #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst,
  lagr_req_if.sink     req,
  lagr_rsp_if.source   rsp
);
  import lagr_pkg::*;

  localparam int IW  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int NW  = 33 + FRAC_BITS;
  localparam int DCW = $clog2(NW + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_AREQ, S_AWAIT, S_ACMP, S_AWR,
    S_IREQ, S_IWAIT, S_ILOAD, S_J, S_JWAIT, S_JLOAD,
    S_DIV, S_RAT, S_MUL, S_SCL, S_SUM, S_FIN
  } state_t;

  state_t                 state;
  logic [WORD_W-1:0]      x_mem [MAX_POINTS];
  logic [WORD_W-1:0]      y_mem [MAX_POINTS];
  logic [IW-1:0]          rd_addr;
  logic signed [31:0]     x_rd, y_rd;

  logic [CW-1:0]          count;
  logic                   dup_seen;
  action_t                act;
  logic signed [31:0]     px, py, qx, xi;
  logic [IW-1:0]          i, j;
  logic signed [31:0]     term, ratio, sum;
  logic signed [63:0]     prod;
  logic                   ovf, neg;
  logic [NW-1:0]          quo;
  logic [33:0]            rem;
  logic [32:0]            dvs;
  logic [DCW-1:0]         dcnt;
  logic signed [31:0]     res_value;
  status_t                res_status;

  logic [CW-1:0]          cnt_m1;
  logic                   last_j, last_i;
  logic signed [32:0]     num, den;
  logic [32:0]            num_mag, den_mag;
  logic [33:0]            rem_sh;
  logic                   rem_ge;
  logic signed [63:0]     adj, shf;
  logic signed [32:0]     s33;
  logic                   rsp_load;

  assign cnt_m1  = count - CW'(1);
  assign last_j  = (j == cnt_m1[IW-1:0]);
  assign last_i  = (i == cnt_m1[IW-1:0]);
  assign num     = {qx[31], qx} - {x_rd[31], x_rd};
  assign den     = {xi[31], xi} - {x_rd[31], x_rd};
  assign num_mag = num[32] ? 33'(-num) : 33'(num);
  assign den_mag = den[32] ? 33'(-den) : 33'(den);
  assign rem_sh  = {rem[32:0], quo[NW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dvs});
  // Shift toward zero: bias negative products before the arithmetic shift.
  assign adj     = prod + (prod[63] ? {{(64-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}} : 64'sd0);
  assign shf     = adj >>> FRAC_BITS;
  assign s33     = {sum[31], sum} + {term[31], term};
  assign rsp_load = (state == S_FIN) && (!rsp.valid || rsp.ready);

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (state == S_AWR) begin
      x_mem[count[IW-1:0]] <= px;
      y_mem[count[IW-1:0]] <= py;
    end
    x_rd <= x_mem[rd_addr];
    y_rd <= y_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dup_seen  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp_load) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            act   <= req.action;
            px    <= req.point_x;
            py    <= req.point_y;
            qx    <= req.query_x;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          res_value  <= '0;
          res_status <= ST_OK;
          state      <= S_FIN;
          case (act)
            ACT_CLEAR: begin
              count    <= '0;
              dup_seen <= 1'b0;
            end
            ACT_APPEND: begin
              if (count >= CW'(MAX_POINTS)) begin
                res_status <= ST_FULL;
              end else if (count == '0) begin
                state <= S_AWR;
              end else begin
                j     <= '0;
                state <= S_AREQ;
              end
            end
            ACT_EVAL: begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
              end else if (dup_seen) begin
                res_status <= ST_DUP;
              end else begin
                i     <= '0;
                sum   <= '0;
                ovf   <= 1'b0;
                state <= S_IREQ;
              end
            end
            default: ;
          endcase
        end
        S_AREQ: begin
          rd_addr <= j;
          state   <= S_AWAIT;
        end
        S_AWAIT: state <= S_ACMP;
        S_ACMP: begin
          if (x_rd == px) begin
            dup_seen   <= 1'b1;
            res_status <= ST_DUP;
          end
          if (last_j) begin
            state <= S_AWR;
          end else begin
            j     <= j + IW'(1);
            state <= S_AREQ;
          end
        end
        S_AWR: begin
          count <= count + CW'(1);
          state <= S_FIN;
        end
        S_IREQ: begin
          rd_addr <= i;
          state   <= S_IWAIT;
        end
        S_IWAIT: state <= S_ILOAD;
        S_ILOAD: begin
          xi    <= x_rd;
          term  <= y_rd;
          j     <= '0;
          state <= S_J;
        end
        S_J: begin
          if (j == i) begin
            if (last_j) state <= S_SUM;
            else j <= j + IW'(1);
          end else begin
            rd_addr <= j;
            state   <= S_JWAIT;
          end
        end
        S_JWAIT: state <= S_JLOAD;
        S_JLOAD: begin
          if (den == '0) begin
            res_status <= ST_DUP;
            res_value  <= '0;
            state      <= S_FIN;
          end else begin
            quo   <= {num_mag, {FRAC_BITS{1'b0}}};
            dvs   <= den_mag;
            rem   <= '0;
            neg   <= num[32] ^ den[32];
            dcnt  <= DCW'(NW);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem   <= rem_ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
          quo   <= {quo[NW-2:0], rem_ge};
          dcnt  <= dcnt - DCW'(1);
          if (dcnt == DCW'(1)) state <= S_RAT;
        end
        S_RAT: begin
          if (neg) begin
            if ((|quo[NW-1:32]) || (quo[31] && (|quo[30:0]))) begin
              ratio <= 32'sh8000_0000;
              ovf   <= 1'b1;
            end else begin
              ratio <= -$signed(quo[31:0]);
            end
          end else begin
            if (|quo[NW-1:31]) begin
              ratio <= 32'sh7FFF_FFFF;
              ovf   <= 1'b1;
            end else begin
              ratio <= $signed(quo[31:0]);
            end
          end
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= term * ratio;
          state <= S_SCL;
        end
        S_SCL: begin
          if (!shf[63] && (|shf[62:31])) begin
            term <= 32'sh7FFF_FFFF;
            ovf  <= 1'b1;
          end else if (shf[63] && !(&shf[62:31])) begin
            term <= 32'sh8000_0000;
            ovf  <= 1'b1;
          end else begin
            term <= shf[31:0];
          end
          if (last_j) begin
            state <= S_SUM;
          end else begin
            j     <= j + IW'(1);
            state <= S_J;
          end
        end
        S_SUM: begin
          if (s33[32] != s33[31]) begin
            sum <= s33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            ovf <= 1'b1;
          end else begin
            sum <= s33[31:0];
          end
          if (last_i) begin
            state <= S_FIN;
            // The result is picked up from sum and ovf in the final state.
            res_status <= ST_OVF;
          end else begin
            i     <= i + IW'(1);
            state <= S_IREQ;
          end
        end
        S_FIN: begin
          if (rsp_load) begin
            if (act == ACT_EVAL && res_status == ST_OVF) begin
              rsp.value  <= sum;
              rsp.status <= ovf ? ST_OVF : ST_OK;
            end else begin
              rsp.value  <= res_value;
              rsp.status <= res_status;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/lagr_checker.sv
// Port-level checks on the evaluator, bound to the evaluator core module.
module lagr_checker (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic signed [31:0] rsp_value,
  input lagr_pkg::status_t  rsp_status
);
  import lagr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid straight after reset");

  a_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_EMPTY || rsp_status == ST_DUP ||
                   rsp_status == ST_FULL || rsp_status == ST_OVF))
    else $error("undefined status code");

  a_errzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_DUP || rsp_status == ST_FULL)
    |-> rsp_value == '0)
    else $error("non-zero value with error status");

endmodule

bind lagrange_interpolation_eval_core lagr_checker u_lagr_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_value  (rsp.value),
  .rsp_status (rsp.status)
);
